@@ src/lcg48_ranged_random_assert.svh @@
// Assertion macros for the ranged LCG block.
`ifndef LCG48_RANGED_RANDOM_ASSERT_SVH
`define LCG48_RANGED_RANDOM_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define LRR_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// A signal stays stable while a condition holds into the next cycle.
`define LRR_ASSERT_HOLD(lbl, clk, rstn, cond, sig, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) \
    (cond) |=> $stable(sig)) else $error(msg);
`endif

@@ src/lrr_pkg.sv @@
// ----------------------------------------------------------------------------
// lrr_pkg
// Shared types and constants of the ranged LCG generator.
// ----------------------------------------------------------------------------
package lrr_pkg;
  localparam int unsigned StateW = 48;
  localparam logic [47:0] LcgMult = 48'h0005_DEEC_E66D;
  localparam logic [47:0] LcgAdd = 48'h0000_0000_000B;
  localparam logic [15:0] SeedLow = 16'h330E;
  localparam int unsigned InW = 259;  // 3+32+32+64+64+64
  localparam int unsigned OutW = 96;

  typedef enum logic [2:0] {
    OP_SEED = 3'd0, OP_RAND32 = 3'd1, OP_RAND64 = 3'd2,
    OP_RANGE32 = 3'd3, OP_RANGE64 = 3'd4
  } op_e;

  // Classified command between front and back.
  typedef struct packed {
    logic        seed_op;   // load seed
    logic        draw;      // perform draw
    logic        wide;      // three steps / 64-bit
    logic        zero_out;  // no draw, value = base
    logic [31:0] seed;
    logic [63:0] modulus;
    logic [63:0] base;      // added after draw (or returned)
    logic        trunc32;
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_MUL, ST_DIV, ST_ADD, ST_OUT
  } bk_state_e;
endpackage

@@ src/lrr_front.sv @@
// ----------------------------------------------------------------------------
// lrr_front
// Accepts requests, classifies them, and holds a two-entry command queue.
// ----------------------------------------------------------------------------
module lrr_front import lrr_pkg::*; (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  output logic           ready_o,
  input  logic [InW-1:0] data_i,
  output logic           cmd_valid_o,
  input  logic           cmd_ready_i,
  output cmd_t           cmd_o
);
  logic [2:0]  op;
  logic [31:0] sv, fb;
  logic [63:0] lim, lo, up, span;
  cmd_t c;
  cmd_t q_q [2];
  logic [1:0] cnt_q;
  logic push, pop;

  assign op   = data_i[2:0];
  assign sv   = data_i[34:3];
  assign fb   = data_i[66:35];
  assign lim  = data_i[130:67];
  assign lo   = data_i[194:131];
  assign up   = data_i[258:195];
  assign span = up - lo + 64'd1;

  always_comb begin
    c = '0;
    c.seed = (sv == 32'd0) ? fb : sv;
    unique case (op)
      OP_SEED: c.seed_op = 1'b1;
      OP_RAND32, OP_RAND64: begin
        c.wide = (op == OP_RAND64);
        c.trunc32 = (op == OP_RAND32);
        c.modulus = lim;
        c.draw = (lim != 64'd0);
        c.zero_out = (lim == 64'd0);
      end
      OP_RANGE32, OP_RANGE64: begin
        c.wide = (op == OP_RANGE64);
        c.trunc32 = (op == OP_RANGE32);
        c.base = lo;
        c.modulus = span;
        c.draw = (lo != up) && (span != 64'd0);
        c.zero_out = !c.draw;
      end
      default: c.zero_out = 1'b1;
    endcase
  end

  assign ready_o = (cnt_q != 2'd2);
  assign push = valid_i && ready_o;
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign pop = cmd_valid_o && cmd_ready_i;
  assign cmd_o = q_q[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

  // push is never taken while full, so a pop with push leaves one entry
  always_ff @(posedge clk_i) begin
    if (pop) begin
      if (push && cnt_q == 2'd1) q_q[0] <= c;
      else q_q[0] <= q_q[1];
    end else if (push) begin
      if (cnt_q == 2'd0) q_q[0] <= c;
      else q_q[1] <= c;
    end
  end
endmodule

@@ src/lrr_back.sv @@
// ----------------------------------------------------------------------------
// lrr_back
// Steps the 48-bit LCG as partial products, then their sum, reduces the draw
// by a restoring divider, adds base; also loads seeds and returns no-draw base.
// ----------------------------------------------------------------------------
module lrr_back import lrr_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cmd_valid_i,
  output logic            cmd_ready_o,
  input  cmd_t            cmd_i,
  output logic            valid_o,
  input  logic            ready_i,
  output logic [OutW-1:0] data_o
);
  bk_state_e st_q, st_d;
  cmd_t cmd_q;
  logic [StateW-1:0] lcg_q;
  logic [47:0] nxt;
  logic [47:0] prod_lo, plo_q;
  logic [23:0] prod_hi, phi_q;
  logic        ph_q;
  logic [30:0] s1_q, s2_q;
  logic [1:0]  step_q;
  logic [5:0]  bit_q;
  logic [63:0] dvd_q, rem_q, res_q;
  logic [64:0] trial;

  // one LCG step, mod 2^48, split on state bit 24:
  // lo24 * M + ((hi24 * M[23:0]) mod 2^24) << 24
  assign prod_lo = 48'(lcg_q[23:0]) * 48'(LcgMult[34:0]);
  assign prod_hi = lcg_q[47:24] * LcgMult[23:0];
  assign nxt = plo_q + {phi_q, 24'd0} + LcgAdd;
  assign trial = {rem_q, dvd_q[63]} - {1'b0, cmd_q.modulus};
  assign cmd_ready_o = (st_q == ST_IDLE);
  assign valid_o = (st_q == ST_OUT);
  assign data_o = {lcg_q[47:16], res_q};

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      ST_IDLE: if (cmd_valid_i) st_d = ST_MUL;
      ST_MUL: begin
        if (cmd_q.seed_op || cmd_q.zero_out) st_d = ST_OUT;
        else if (ph_q && step_q == (cmd_q.wide ? 2'd2 : 2'd1)) st_d = ST_DIV;
      end
      ST_DIV: if (bit_q == 6'd63) st_d = ST_ADD;
      ST_ADD: st_d = ST_OUT;
      ST_OUT: if (ready_i) st_d = ST_IDLE;
      default: st_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= ST_IDLE;
      lcg_q <= '0;
    end else begin
      st_q <= st_d;
      if (st_q == ST_MUL) begin
        if (cmd_q.seed_op) lcg_q <= {cmd_q.seed, SeedLow};
        else if (!cmd_q.zero_out && ph_q) lcg_q <= nxt;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (st_q)
      ST_IDLE: begin
        cmd_q <= cmd_i;
        step_q <= 2'd0;
        ph_q <= 1'b0;
        bit_q <= 6'd0;
        rem_q <= '0;
      end
      ST_MUL: begin
        if (cmd_q.seed_op) res_q <= {32'd0, cmd_q.seed};
        else if (cmd_q.zero_out)
          res_q <= cmd_q.trunc32 ? {32'd0, cmd_q.base[31:0]} : cmd_q.base;
        else if (!ph_q) begin
          // first half of a step: partial products
          ph_q <= 1'b1;
          plo_q <= prod_lo;
          phi_q <= prod_hi;
        end else begin
          // second half: sum lands in the state, take the sample
          ph_q <= 1'b0;
          step_q <= step_q + 2'd1;
          if (step_q == 2'd0) s1_q <= nxt[47:17];
          else if (step_q == 2'd1) begin
            s2_q <= nxt[47:17];
            if (!cmd_q.wide) dvd_q <= {32'd0, nxt[17], s1_q};
          end else begin
            dvd_q <= {nxt[17], s1_q, nxt[18], s2_q};
          end
        end
      end
      ST_DIV: begin
        bit_q <= bit_q + 6'd1;
        if (!trial[64]) rem_q <= trial[63:0];
        else rem_q <= {rem_q[62:0], dvd_q[63]};
        dvd_q <= {dvd_q[62:0], 1'b0};
      end
      ST_ADD: begin
        res_q <= cmd_q.trunc32 ? {32'd0, rem_q[31:0] + cmd_q.base[31:0]}
                               : rem_q + cmd_q.base;
      end
      default: ;
    endcase
  end
endmodule

@@ src/lcg48_ranged_random.sv @@
// ----------------------------------------------------------------------------
// lcg48_ranged_random
// drand48-style generator with seed, modulo draw and ranged draw requests.
// ----------------------------------------------------------------------------
// Usage:
//  - s_axis carries one request: opcode, seed_value, fallback_seed, limit,
//    lower, upper. m_axis returns value and seed_now for each request.
//  - A front stage classifies each request (span, zero limit, equal bounds)
//    and queues up to two commands; the back stage executes one at a time.
//  - Path from request accept to m_axis_tvalid: the front queue, the back
//    stage's IDLE and MUL states, then OUT for seed or no-draw requests;
//    draws run 2 LCG steps in MUL (64-bit draws one more), then DIV and ADD.
//  - The back stage is busy with a request from MUL through OUT and takes
//    no new one until it returns to IDLE; draws pass the one-bit-per-cycle
//    restoring divider.
//  - Each LCG step registers the partial products, then the sum.
//  - Reset clears the LCG state to zero and empties the queue.
//  - When m_axis stalls the result holds; the queue keeps taking requests
//    until full.
// ----------------------------------------------------------------------------
`include "lcg48_ranged_random_assert.svh"
module lcg48_ranged_random import lrr_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // opcode, seed_value, fallback_seed, limit, lower, upper (zero pad)
  input  logic [263:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // value, seed_now
  output logic [95:0]  m_axis_tdata
);
  cmd_t cmd;
  logic cmd_valid, cmd_ready;

  lrr_front u_front (
    .clk_i, .rst_ni,
    .valid_i(s_axis_tvalid), .ready_o(s_axis_tready),
    .data_i(s_axis_tdata[InW-1:0]),
    .cmd_valid_o(cmd_valid), .cmd_ready_i(cmd_ready), .cmd_o(cmd)
  );

  lrr_back u_back (
    .clk_i, .rst_ni,
    .cmd_valid_i(cmd_valid), .cmd_ready_o(cmd_ready), .cmd_i(cmd),
    .valid_o(m_axis_tvalid), .ready_i(m_axis_tready), .data_o(m_axis_tdata)
  );

  `LRR_ASSERT(a_no_take_busy, clk_i, rst_ni, (cmd_valid && cmd_ready) |=> !cmd_ready, "back took a command while busy")
  `LRR_ASSERT_HOLD(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tdata, "result changed under stall")
  `LRR_ASSERT(a_out_exclusive, clk_i, rst_ni, m_axis_tvalid |-> !cmd_ready, "result shown while back idle")
endmodule
